// ===== hw/rtl/ccr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared types and constants for the charge cloud redeposit block.
// ----------------------------------------------------------------------------
package ccr_pkg;

	localparam int ONE_Q15 = 32768;  // 1.0 in Q.15
	localparam int CRD_W   = 6;      // internal coordinate width (neighbor may reach 32)
	localparam int LANES   = 3;      // x, y, z

	typedef logic signed [16:0] ofs_t;  // Q1.15 offset, range [-1, 1]

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic done;
	} div_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ccr_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccr_div
// Three-lane restoring divider: o = clamp((m * 2^15) / d, -1, 1), one
// quotient bit per lane per cycle.
// ----------------------------------------------------------------------------
module ccr_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ccr_pkg::div_ctl_t   ctl,
	input  wire logic signed [31:0]  m [ccr_pkg::LANES],
	input  wire logic signed [32:0]  d,
	output ccr_pkg::div_sts_t        sts,
	output ccr_pkg::ofs_t            o [ccr_pkg::LANES]
);

	logic [32:0] dmag_q;
	logic        dz_q;
	logic [33:0] r_q   [ccr_pkg::LANES];
	logic [16:0] n_q   [ccr_pkg::LANES];
	logic [16:0] qt_q  [ccr_pkg::LANES];
	logic        ovf_q [ccr_pkg::LANES];
	logic        neg_q [ccr_pkg::LANES];
	logic        mneg_q[ccr_pkg::LANES];
	logic        mz_q  [ccr_pkg::LANES];
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [32:0] dmag;
	assign dmag = d[32] ? 33'(-d) : 33'(d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd16) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dmag_q <= dmag;
			dz_q   <= (d == '0);
		end
		for (int i = 0; i < ccr_pkg::LANES; i++) begin
			logic [31:0] mm;
			logic [33:0] rs;
			mm = m[i][31] ? 32'(-m[i]) : 32'(m[i]);
			rs = {r_q[i][32:0], n_q[i][16]};
			if (ctl.start) begin
				ovf_q[i]  <= {3'b0, mm} >= {dmag, 2'b0};
				r_q[i]    <= {4'b0, mm[31:2]};
				n_q[i]    <= {mm[1:0], 15'b0};
				qt_q[i]   <= '0;
				neg_q[i]  <= m[i][31] ^ d[32];
				mneg_q[i] <= m[i][31];
				mz_q[i]   <= (m[i] == '0);
			end else if (busy_q) begin
				n_q[i] <= {n_q[i][15:0], 1'b0};
				if (rs >= {1'b0, dmag_q}) begin
					r_q[i]  <= rs - {1'b0, dmag_q};
					qt_q[i] <= {qt_q[i][15:0], 1'b1};
				end else begin
					r_q[i]  <= rs;
					qt_q[i] <= {qt_q[i][15:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < ccr_pkg::LANES; i++) begin
			logic [16:0] mag;
			logic        sg;
			if (dz_q) begin
				mag = mz_q[i] ? 17'd0 : 17'(ccr_pkg::ONE_Q15);
				sg  = mneg_q[i];
			end else begin
				mag = (ovf_q[i] || qt_q[i] > 17'(ccr_pkg::ONE_Q15)) ?
					17'(ccr_pkg::ONE_Q15) : qt_q[i];
				sg  = neg_q[i];
			end
			o[i] = sg ? -$signed(mag) : $signed(mag);
		end
	end

	assign sts.done = done_q;

endmodule
`default_nettype wire

// ===== hw/rtl/charge_cloud_redeposit_3d.sv =====
`default_nettype none
// Read word: ST_RD1 reads the cell, ST_RD2 captures and clears it, ST_RD3 loads
//   the result once free. Deposit word: divider, then ST_W1-W4 for 8 corners.
// Throughput: one word at a time; the single-port accumulator memory takes one
//   read and one write per corner, and the shared divider runs 17 bit steps.
// Reset: after arst_n releases, a clearing pass writes zero to all
//   GRID_X*GRID_Y*GRID_Z cells before in_ready rises.
// ----------------------------------------------------------------------------
// charge_cloud_redeposit_3d
// Cloud-in-cell charge redeposition into an accumulator memory with
// read-and-clear access.
// ----------------------------------------------------------------------------
module charge_cloud_redeposit_3d #(
	parameter int GRID_X = 32,
	parameter int GRID_Y = 32,
	parameter int GRID_Z = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               action,
	input  wire logic [4:0]         cell_x,
	input  wire logic [4:0]         cell_y,
	input  wire logic [4:0]         cell_z,
	input  wire logic signed [31:0] charge,
	input  wire logic signed [31:0] moment_x,
	input  wire logic signed [31:0] moment_y,
	input  wire logic signed [31:0] moment_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      smoothed_charge
);

	localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = ccr_pkg::CRD_W;

	// controller states
	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_DIV  = 4'd2;
	localparam logic [3:0] ST_W1   = 4'd3;  // wz*wy, corner address
	localparam logic [3:0] ST_W2   = 4'd4;  // * wx
	localparam logic [3:0] ST_W3   = 4'd5;  // * |q|, read cell
	localparam logic [3:0] ST_W4   = 4'd6;  // saturating add, write back
	localparam logic [3:0] ST_RD1  = 4'd7;  // read cell
	localparam logic [3:0] ST_RD2  = 4'd8;  // capture, clear cell
	localparam logic [3:0] ST_RD3  = 4'd9;  // hand to output register

	logic [3:0]          state_q;
	logic [AW-1:0]       clr_q;
	logic                eps_pos_q;
	logic [2:0]          corner_q;
	logic [CW-1:0]       c0_q [ccr_pkg::LANES];
	logic [CW-1:0]       nb_q [ccr_pkg::LANES];
	logic [15:0]         wf_q [ccr_pkg::LANES];
	logic [15:0]         wn_q [ccr_pkg::LANES];
	logic [31:0]         qmag_q;
	logic                qneg_q;
	logic [31:0]         p1_q;
	logic [15:0]         w_q;
	logic signed [33:0]  v_q;
	logic [AW-1:0]       addr_q;
	logic                rd_in_q;   // read address is inside the grid
	logic signed [31:0]  rd_q;
	logic                out_valid_q;
	logic signed [31:0]  out_data_q;

	// accumulator memory, single port
	logic signed [31:0]  mem [CELLS];
	logic signed [31:0]  rdata_q;
	logic                mem_we;
	logic [AW-1:0]       mem_addr;
	logic signed [31:0]  mem_wd;

	// divider
	ccr_pkg::div_ctl_t   div_ctl;
	ccr_pkg::div_sts_t   div_sts;
	ccr_pkg::ofs_t       div_o [ccr_pkg::LANES];
	logic signed [31:0]  div_m [ccr_pkg::LANES];
	logic signed [32:0]  div_d;

	logic accept;
	logic interior;
	logic in_grid;
	logic [31:0] rd_idx;
	logic out_load;   // result register takes a new word this cycle

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign smoothed_charge = out_data_q;
	assign out_load  = (state_q == ST_RD3) && (!out_valid_q || out_ready);

	// deposit only from cells with a neighbor on both sides in every axis
	assign interior = (cell_x != 5'd0) && (32'(cell_x) + 32'd2 <= 32'(GRID_X)) &&
		(cell_y != 5'd0) && (32'(cell_y) + 32'd2 <= 32'(GRID_Y)) &&
		(cell_z != 5'd0) && (32'(cell_z) + 32'd2 <= 32'(GRID_Z));
	assign in_grid = (32'(cell_x) < 32'(GRID_X)) && (32'(cell_y) < 32'(GRID_Y)) &&
		(32'(cell_z) < 32'(GRID_Z));
	assign rd_idx = (32'(cell_z) * 32'(GRID_Y) + 32'(cell_y)) * 32'(GRID_X) + 32'(cell_x);

	// q + eps, eps = one Q16.16 LSB of either sign
	assign div_d = eps_pos_q ? 33'(charge) + 33'sd1 : 33'(charge) - 33'sd1;
	assign div_m[0] = moment_x;
	assign div_m[1] = moment_y;
	assign div_m[2] = moment_z;
	assign div_ctl.start = accept && !action && interior;

	ccr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.m      (div_m),
		.d      (div_d),
		.sts    (div_sts),
		.o      (div_o)
	);

	// corner address and products
	logic [CW-1:0]      cx, cy, cz;
	logic [31:0]        c_idx;
	logic [47:0]        p2;
	logic [47:0]        p3;
	logic [32:0]        mag;
	logic signed [33:0] sum;
	logic signed [31:0] sat;

	always_comb begin
		cx = corner_q[0] ? nb_q[0] : c0_q[0];
		cy = corner_q[1] ? nb_q[1] : c0_q[1];
		cz = corner_q[2] ? nb_q[2] : c0_q[2];
		c_idx = (32'(cz) * 32'(GRID_Y) + 32'(cy)) * 32'(GRID_X) + 32'(cx);
		p2  = 48'(p1_q) * 48'(corner_q[0] ? wf_q[0] : wn_q[0]);
		p3  = 48'(qmag_q) * 48'(w_q);
		mag = p3[47:15];
		sum = 34'(rdata_q) + v_q;
		if (sum > 34'sd2147483647)
			sat = 32'sh7fffffff;
		else if (sum < -34'sd2147483648)
			sat = 32'sh80000000;
		else
			sat = sum[31:0];
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_addr = addr_q;
		mem_wd   = '0;
		case (state_q)
			ST_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			ST_RD2: begin
				mem_we = rd_in_q;
			end
			ST_W4: begin
				mem_we = 1'b1;
				mem_wd = sat;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wd;
		rdata_q <= mem[mem_addr];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			corner_q    <= '0;
			eps_pos_q   <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				eps_pos_q <= cfg_wdata;
			// result register: load from read path, else drop on handshake
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(CELLS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						if (action)
							state_q <= ST_RD1;
						else if (interior)
							state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					corner_q <= '0;
					if (div_sts.done)
						state_q <= ST_W1;
				end
				ST_W1: state_q <= ST_W2;
				ST_W2: state_q <= ST_W3;
				ST_W3: state_q <= ST_W4;
				ST_W4: begin
					corner_q <= corner_q + 3'd1;
					state_q  <= (corner_q == 3'd7) ? ST_IDLE : ST_W1;
				end
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: state_q <= ST_RD3;
				ST_RD3: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			c0_q[0] <= CW'(cell_x);
			c0_q[1] <= CW'(cell_y);
			c0_q[2] <= CW'(cell_z);
			qneg_q  <= charge[31];
			qmag_q  <= charge[31] ? 32'(-charge) : 32'(charge);
			addr_q  <= rd_idx[AW-1:0];
			rd_in_q <= in_grid;
		end
		if (state_q == ST_DIV && div_sts.done) begin
			for (int i = 0; i < ccr_pkg::LANES; i++) begin
				logic [16:0] a;
				a = div_o[i][16] ? 17'(-div_o[i]) : 17'(div_o[i]);
				wf_q[i] <= a[15:0];
				wn_q[i] <= 16'(17'(ccr_pkg::ONE_Q15) - a);
				// neighbor on the side the offset points to; zero offset goes low
				nb_q[i] <= (!div_o[i][16] && div_o[i] != '0) ?
					c0_q[i] + CW'(1) : c0_q[i] - CW'(1);
			end
		end
		if (state_q == ST_W1) begin
			p1_q   <= 32'(corner_q[2] ? wf_q[2] : wn_q[2]) *
				32'(corner_q[1] ? wf_q[1] : wn_q[1]);
			addr_q <= c_idx[AW-1:0];
		end
		if (state_q == ST_W2)
			w_q <= p2[45:30];
		if (state_q == ST_W3)
			v_q <= qneg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		if (state_q == ST_RD2)
			rd_q <= rd_in_q ? rdata_q : '0;
		if (out_load)
			out_data_q <= rd_q;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ccr_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccr_chk
// Port-level checks for charge_cloud_redeposit_3d, bound to the top level.
// ----------------------------------------------------------------------------
module ccr_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        action,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] smoothed_charge
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(smoothed_charge))
		else $error("result word changed while stalled");

	// a read word keeps the block busy while the cell is read and cleared
	a_rd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action |=> !in_ready)
		else $error("input taken during read");

	// a deposit word never makes a result
	a_dep_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !action |=> !$rose(out_valid))
		else $error("result after deposit word");

endmodule

bind charge_cloud_redeposit_3d ccr_chk u_ccr_chk (.*);
`default_nettype wire
